// ===== sv/scof_pkg.sv =====
// scof_pkg: shared types and constants of the sigma clip outlier filter
// holds the command codes, the fetch sequencer states and the payload structs
// no dependencies
package scof_pkg;

   // field widths fixed by the point format
   localparam int COORD_BITS     = 24;
   localparam int LINE_BITS      = 8;
   localparam int FETCH_IDX_BITS = 12;

   // digit width of the shared iterative multiplier
   localparam int MUL_DIGIT_BITS = 8;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_FETCH = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_NSQ,
      ST_S2,
      ST_D2,
      ST_LHS,
      ST_RHS,
      ST_OUT
   } state_type;

   typedef struct packed {
      cmd_type                        cmd;
      logic signed [COORD_BITS-1:0]   point_x;
      logic signed [COORD_BITS-1:0]   point_y;
      logic signed [COORD_BITS-1:0]   point_z;
      logic [LINE_BITS-1:0]           line_id;
      logic [FETCH_IDX_BITS-1:0]      fetch_index;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]   out_x;
      logic signed [COORD_BITS-1:0]   out_y;
      logic signed [COORD_BITS-1:0]   out_z;
      logic [LINE_BITS-1:0]           out_line;
      logic                           keep;
      logic                           index_valid;
      logic                           overflowed;
   } rsp_type;

   // one stored point as it sits in the point memory
   typedef struct packed {
      logic signed [COORD_BITS-1:0]   x;
      logic signed [COORD_BITS-1:0]   y;
      logic signed [COORD_BITS-1:0]   z;
      logic [LINE_BITS-1:0]           line;
   } point_type;

endpackage

// ===== sv/scof_mul.sv =====
// scof_mul: iterative unsigned multiplier, one digit of the b operand a cycle
// most significant digit first, result held until the next start
// depends on scof_pkg for the digit width
module scof_mul #(
   parameter int A_W = 88,
   parameter int B_W = 38
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [A_W-1:0] a,
   input  logic [B_W-1:0] b,
   output logic           done,
   output logic [A_W-1:0] product
);

   localparam int DIG    = scof_pkg::MUL_DIGIT_BITS;
   localparam int NDIG   = (B_W + DIG - 1) / DIG;
   localparam int PAD_W  = NDIG * DIG;
   localparam int CNT_W  = (NDIG > 1) ? $clog2(NDIG) : 1;

   logic [A_W-1:0]     a_ff,    a_in;
   logic [PAD_W-1:0]   b_ff,    b_in;
   logic [A_W-1:0]     acc_ff,  acc_in;
   logic [CNT_W-1:0]   cnt_ff,  cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [DIG-1:0]     digit;
   logic [A_W+DIG-1:0] part;

   // top digit of the shifting b operand times a
   assign digit = b_ff[PAD_W-1 -: DIG];
   assign part  = (A_W+DIG)'(a_ff) * (A_W+DIG)'(digit);

   // shift-add step and digit count
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = PAD_W'(b);
         acc_in  = '0;
         cnt_in  = CNT_W'(NDIG - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = (acc_ff << DIG) + part[A_W-1:0];
         b_in   = b_ff << DIG;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== sv/sigma_clip_outlier_filter.sv =====
// sigma_clip_outlier_filter: point store with running height statistics and
// a two-sigma keep decision on fetch
// depends on scof_pkg and scof_mul
//
// usage
//   req channel carries one command per transfer: clear the set, load a point
//   or fetch a stored point by load index. only a fetch produces a transfer on
//   the rsp channel; clear and load take effect when accepted.
//   a fetch first reads the point memory and then runs five products
//   through one shared digit-serial multiplier of NDIG = ceil(SUM_W / 8)
//   digits each: n*sumsq, sum^2, d^2, d^2*(n-1) and 4n*(n*sumsq - sum^2).
//   a fetch that is out of range or sees fewer than two points skips the
//   products and goes straight to the output register.
//   req_stall is high while a fetch is in work; one item is handled at a time.
//   the result sits in an output register, so loads and clears are taken
//   while rsp_stall holds a result; a finished fetch waits for that register.
//   reset clears the count, sums, overflow flag and the output valid flag; the
//   point memory has no reset, and entries at or above the count are never
//   returned.
module sigma_clip_outlier_filter #(
   parameter int MAX_POINTS = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  scof_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output scof_pkg::rsp_type rsp_data
);

   localparam int C      = scof_pkg::COORD_BITS;
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int SUM_W  = C + CNT_W + 1;
   localparam int SQ_W   = 2 * C - 1 + CNT_W;
   localparam int CMP_W  = 2 * C + 3 * CNT_W + 1;
   localparam int IDX_W  = (scof_pkg::FETCH_IDX_BITS > CNT_W) ?
                           scof_pkg::FETCH_IDX_BITS : CNT_W;

   // point memory
   scof_pkg::point_type mem [MAX_POINTS];
   scof_pkg::point_type rd_ff;

   // statistics and control
   scof_pkg::state_type     state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff,   sum_in;
   logic [SQ_W-1:0]         sumsq_ff, sumsq_in;
   logic                    ovf_ff,   ovf_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // fetch datapath
   logic                    idx_ok_ff;
   logic                    ovf_seen_ff;
   logic                    keep_ff;
   logic signed [SUM_W-1:0] nz_ff;
   logic [SUM_W-1:0]        d_ff;
   logic [CMP_W-1:0]        nsq_ff;
   logic [CMP_W-1:0]        s2_ff;
   logic [CMP_W-1:0]        lhs_ff;
   scof_pkg::rsp_type       rsp_ff;

   logic                    accept;
   logic                    is_load;
   logic                    is_fetch;
   logic                    do_write;
   logic [IDX_W-1:0]        idx_ext;
   logic                    idx_ok;
   logic [ADDR_W-1:0]       rd_addr;
   logic [ADDR_W-1:0]       wr_addr;
   logic signed [2*C-1:0]   zsq;
   logic [SUM_W-1:0]        sum_mag;
   logic signed [SUM_W:0]   dev;
   logic                    out_free;
   logic                    out_load;

   logic                    mul_start;
   logic [CMP_W-1:0]        mul_a;
   logic [SUM_W-1:0]        mul_b;
   logic                    mul_done;
   logic [CMP_W-1:0]        mul_p;

   scof_mul #(
      .A_W (CMP_W),
      .B_W (SUM_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   // request decode
   assign accept   = req_valid && !req_stall;
   assign is_load  = accept && (req_data.cmd == scof_pkg::CMD_LOAD);
   assign is_fetch = accept && (req_data.cmd == scof_pkg::CMD_FETCH);
   assign do_write = is_load && (count_ff != CNT_W'(MAX_POINTS));
   assign idx_ext  = IDX_W'(req_data.fetch_index);
   assign idx_ok   = idx_ext < IDX_W'(count_ff);
   assign rd_addr  = idx_ext[ADDR_W-1:0];
   assign wr_addr  = count_ff[ADDR_W-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (state_ff == scof_pkg::ST_OUT) && out_free;
   assign req_stall = (state_ff != scof_pkg::ST_IDLE);

   // height terms used by the running sums and the keep decision
   assign zsq     = req_data.point_z * req_data.point_z;
   assign sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign dev     = (SUM_W+1)'(nz_ff) - (SUM_W+1)'(sum_ff);

   // point memory write on load, registered read on fetch
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[wr_addr] <= '{x: req_data.point_x, y: req_data.point_y,
                           z: req_data.point_z, line: req_data.line_id};
      end
      if (is_fetch) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // running count and sums
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      sumsq_in = sumsq_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         case (req_data.cmd)
            scof_pkg::CMD_CLEAR: begin
               count_in = '0;
               sum_in   = '0;
               sumsq_in = '0;
               ovf_in   = 1'b0;
            end
            scof_pkg::CMD_LOAD: begin
               if (do_write) begin
                  count_in = count_ff + CNT_W'(1);
                  sum_in   = sum_ff + SUM_W'(req_data.point_z);
                  sumsq_in = sumsq_ff + SQ_W'($unsigned(zsq));
               end else begin
                  ovf_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // fetch sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scof_pkg::ST_IDLE: begin
            if (is_fetch) begin
               state_in = (idx_ok && (count_ff >= CNT_W'(2))) ?
                          scof_pkg::ST_READ : scof_pkg::ST_OUT;
            end
         end
         scof_pkg::ST_READ: state_in = scof_pkg::ST_NSQ;
         scof_pkg::ST_NSQ: begin
            if (mul_done) state_in = scof_pkg::ST_S2;
         end
         scof_pkg::ST_S2: begin
            if (mul_done) state_in = scof_pkg::ST_D2;
         end
         scof_pkg::ST_D2: begin
            if (mul_done) state_in = scof_pkg::ST_LHS;
         end
         scof_pkg::ST_LHS: begin
            if (mul_done) state_in = scof_pkg::ST_RHS;
         end
         scof_pkg::ST_RHS: begin
            if (mul_done) state_in = scof_pkg::ST_OUT;
         end
         scof_pkg::ST_OUT: begin
            if (out_free) state_in = scof_pkg::ST_IDLE;
         end
         default: state_in = scof_pkg::ST_IDLE;
      endcase
   end

   // multiplier launches, each one as the previous product completes
   always_comb begin
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         scof_pkg::ST_READ: begin
            mul_start = 1'b1;
            mul_a     = CMP_W'(sumsq_ff);
            mul_b     = SUM_W'(count_ff);
         end
         scof_pkg::ST_NSQ: begin
            mul_start = mul_done;
            mul_a     = CMP_W'(sum_mag);
            mul_b     = sum_mag;
         end
         scof_pkg::ST_S2: begin
            mul_start = mul_done;
            mul_a     = CMP_W'(d_ff);
            mul_b     = d_ff;
         end
         scof_pkg::ST_D2: begin
            mul_start = mul_done;
            mul_a     = mul_p;
            mul_b     = SUM_W'(count_ff - CNT_W'(1));
         end
         scof_pkg::ST_LHS: begin
            mul_start = mul_done;
            mul_a     = nsq_ff - s2_ff;
            mul_b     = SUM_W'({count_ff, 2'b00});
         end
         default: begin
         end
      endcase
   end

   // output register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scof_pkg::ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sumsq_ff     <= sumsq_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // keep decision datapath
   always_ff @(posedge clock) begin
      if (is_fetch) begin
         idx_ok_ff   <= idx_ok;
         ovf_seen_ff <= ovf_ff;
         keep_ff     <= 1'b0;
      end
      if (state_ff == scof_pkg::ST_READ) begin
         nz_ff <= SUM_W'($signed({1'b0, count_ff})) * SUM_W'(rd_ff.z);
      end
      if (state_ff == scof_pkg::ST_NSQ) begin
         d_ff <= SUM_W'(dev[SUM_W] ? -dev : dev);
      end
      if ((state_ff == scof_pkg::ST_NSQ) && mul_done) nsq_ff <= mul_p;
      if ((state_ff == scof_pkg::ST_S2)  && mul_done) s2_ff  <= mul_p;
      if ((state_ff == scof_pkg::ST_LHS) && mul_done) lhs_ff <= mul_p;
      if ((state_ff == scof_pkg::ST_RHS) && mul_done) begin
         keep_ff <= (s2_ff < nsq_ff) && (lhs_ff < mul_p);
      end
      if (out_load) begin
         rsp_ff.out_x       <= idx_ok_ff ? rd_ff.x : '0;
         rsp_ff.out_y       <= idx_ok_ff ? rd_ff.y : '0;
         rsp_ff.out_z       <= idx_ok_ff ? rd_ff.z : '0;
         rsp_ff.out_line    <= idx_ok_ff ? rd_ff.line : '0;
         rsp_ff.keep        <= keep_ff;
         rsp_ff.index_valid <= idx_ok_ff;
         rsp_ff.overflowed  <= ovf_seen_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
